>>> sv/vrot_pkg.sv
// Shared constants, operation codes and the CORDIC arctangent table for the rotator.
`timescale 1ns / 1ps
`default_nettype none

package vrot_pkg;

  localparam int unsigned VROT_COORD_WIDTH   = 24;
  localparam int unsigned VROT_ANGLE_WIDTH   = 16;
  localparam int unsigned VROT_CORDIC_STAGES = 16;

  // Arctangent table length; stages beyond it are not built.
  localparam int unsigned ATAN_LEN = 24;

  // Sine and cosine are Q2.30 in TRIG_W bits; the angle accumulator is one bit wider.
  localparam int unsigned TRIG_W     = 32;
  localparam int unsigned ZACC_W     = 33;
  localparam int unsigned FRAC_SHIFT = 30;

  // CORDIC gain compensation, Q2.30.
  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;

  typedef enum logic [1:0] {
    OP_ROT_X  = 2'd0,
    OP_ROT_Y  = 2'd1,
    OP_ROT_Z  = 2'd2,
    OP_PLANAR = 2'd3
  } vrot_op_e;

  // Arctangent of 2^-idx in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> sv/vrot_if.sv
// Valid/ready channel interfaces for points in and rotated points out.
`timescale 1ns / 1ps
`default_nettype none

interface vrot_in_if #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [ANGLE_WIDTH-1:0]        angle;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, op, angle, in_x, in_y, in_z, input ready);
  modport sink   (input valid, op, angle, in_x, in_y, in_z, output ready);
endinterface

interface vrot_out_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

>>> sv/vector_axis_rotator_core.sv
// Pipelined elementary 3D rotation: CORDIC sine/cosine, multiply, round and saturate.
//
//  channel  dir  handshake       payload
//  in_i     in   valid / ready   op, angle, in_x, in_y, in_z
//  out_o    out  valid / ready   out_x, out_y, out_z
//
// One point per cycle sustained while out_o is ready; each point passes through the registered
// CORDIC stages and then through the sin/cos, multiply and rounding stages.
// Each stage holds its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles close up and input is taken while a result waits at the output.
// rst_ni clears the valid bits only; the datapath registers carry no reset.
`timescale 1ns / 1ps
`default_nettype none

module vector_axis_rotator_core #(
  parameter int unsigned COORD_WIDTH   = vrot_pkg::VROT_COORD_WIDTH,
  parameter int unsigned ANGLE_WIDTH   = vrot_pkg::VROT_ANGLE_WIDTH,
  parameter int unsigned CORDIC_STAGES = vrot_pkg::VROT_CORDIC_STAGES
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  vrot_in_if.sink     in_i,
  vrot_out_if.source  out_o
);

  import vrot_pkg::*;

  localparam int unsigned NS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  // Stages: 0..NS CORDIC, NS+1 sin/cos, NS+2 products, NS+3 result.
  localparam int unsigned NST = NS + 4;
  localparam int unsigned PW  = COORD_WIDTH + TRIG_W;
  localparam int unsigned SW  = PW + 2;
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Point travelling alongside the trig datapath: (u, v) rotate, w is the axis coordinate.
  typedef struct packed {
    vrot_op_e                      op;
    logic                          flip;
    logic signed [COORD_WIDTH-1:0] u;
    logic signed [COORD_WIDTH-1:0] v;
    logic signed [COORD_WIDTH-1:0] w;
  } pt_t;

  logic [NST-1:0] vld_q;
  logic [NST:0]   rdy;

  pt_t                     pt_d;
  pt_t                     pt_q [NST-1];
  logic signed [TRIG_W-1:0] cx_q [NS+1];
  logic signed [TRIG_W-1:0] cy_q [NS+1];
  logic signed [ZACC_W-1:0] cz_q [NS+1];
  logic signed [ZACC_W-1:0] cz_d;

  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic signed [PW-1:0]     p_uc_q, p_vs_q, p_us_q, p_vc_q;
  logic signed [COORD_WIDTH-1:0] ru, rv;
  logic signed [COORD_WIDTH-1:0] ox_d, oy_d, oz_d;
  logic signed [COORD_WIDTH-1:0] ox_q, oy_q, oz_q;

  // ---------------------------------------------------------------- handshake
  always_comb begin
    rdy[NST] = out_o.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = vld_q[NST-1];
  assign out_o.out_x = ox_q;
  assign out_o.out_y = oy_q;
  assign out_o.out_z = oz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  always_comb begin
    logic [31:0] turn;
    turn        = {in_i.angle, {(32 - ANGLE_WIDTH){1'b0}}};
    pt_d.op     = vrot_op_e'(in_i.op);
    // Angles in [1/4, 3/4) turn: add half a turn, negate sin and cos at the end.
    pt_d.flip   = turn[31] ^ turn[30];
    cz_d        = ZACC_W'($signed({turn[31] ^ pt_d.flip, turn[30:0]}));
    case (pt_d.op)
      OP_ROT_X: begin
        pt_d.u = in_i.in_y; pt_d.v = in_i.in_z; pt_d.w = in_i.in_x;
      end
      OP_ROT_Y: begin
        pt_d.u = in_i.in_z; pt_d.v = in_i.in_x; pt_d.w = in_i.in_y;
      end
      default: begin
        pt_d.u = in_i.in_x; pt_d.v = in_i.in_y; pt_d.w = in_i.in_z;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pt_q[0] <= pt_d;
      cx_q[0] <= GAIN_Q30;
      cy_q[0] <= '0;
      cz_q[0] <= cz_d;
    end
  end

  // ---------------------------------------------------------------- CORDIC stages
  for (genvar k = 0; k < NS; k++) begin : g_cordic
    logic signed [TRIG_W-1:0] dx, dy;
    logic [31:0]              atan_k;

    assign dx     = cy_q[k] >>> k;
    assign dy     = cx_q[k] >>> k;
    assign atan_k = atan_turn(5'(k));

    always_ff @(posedge clk_i) begin
      if (rdy[k+1]) begin
        pt_q[k+1] <= pt_q[k];
        if (!cz_q[k][ZACC_W-1]) begin
          cx_q[k+1] <= cx_q[k] - dx;
          cy_q[k+1] <= cy_q[k] + dy;
          cz_q[k+1] <= cz_q[k] - $signed({1'b0, atan_k});
        end else begin
          cx_q[k+1] <= cx_q[k] + dx;
          cy_q[k+1] <= cy_q[k] - dy;
          cz_q[k+1] <= cz_q[k] + $signed({1'b0, atan_k});
        end
      end
    end
  end

  // ---------------------------------------------------------------- sin/cos, products
  always_ff @(posedge clk_i) begin
    if (rdy[NS+1]) begin
      pt_q[NS+1] <= pt_q[NS];
      cos_q      <= pt_q[NS].flip ? -cx_q[NS] : cx_q[NS];
      sin_q      <= pt_q[NS].flip ? -cy_q[NS] : cy_q[NS];
    end
    if (rdy[NS+2]) begin
      pt_q[NS+2] <= pt_q[NS+1];
      p_uc_q     <= PW'(pt_q[NS+1].u) * PW'(cos_q);
      p_vs_q     <= PW'(pt_q[NS+1].v) * PW'(sin_q);
      p_us_q     <= PW'(pt_q[NS+1].u) * PW'(sin_q);
      p_vc_q     <= PW'(pt_q[NS+1].v) * PW'(cos_q);
    end
  end

  // ---------------------------------------------------------------- round, saturate, map
  always_comb begin
    logic signed [SW-1:0] sum_u, sum_v, sh_u, sh_v;
    sum_u = SW'(p_uc_q) - SW'(p_vs_q) + RND_HALF;
    sum_v = SW'(p_us_q) + SW'(p_vc_q) + RND_HALF;
    sh_u  = sum_u >>> FRAC_SHIFT;
    sh_v  = sum_v >>> FRAC_SHIFT;
    if (sh_u > SW'(COORD_MAX))      ru = COORD_MAX;
    else if (sh_u < SW'(COORD_MIN)) ru = COORD_MIN;
    else                            ru = sh_u[COORD_WIDTH-1:0];
    if (sh_v > SW'(COORD_MAX))      rv = COORD_MAX;
    else if (sh_v < SW'(COORD_MIN)) rv = COORD_MIN;
    else                            rv = sh_v[COORD_WIDTH-1:0];

    case (pt_q[NS+2].op)
      OP_ROT_X: begin
        ox_d = pt_q[NS+2].w; oy_d = ru; oz_d = rv;
      end
      OP_ROT_Y: begin
        ox_d = rv; oy_d = pt_q[NS+2].w; oz_d = ru;
      end
      OP_ROT_Z: begin
        ox_d = ru; oy_d = rv; oz_d = pt_q[NS+2].w;
      end
      default: begin
        ox_d = ru; oy_d = rv; oz_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS+3]) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      oz_q <= oz_d;
    end
  end

`ifndef SYNTH
  // A transfer in always lands in the first stage.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted point did not enter stage 0");

  // Input backpressure only when every stage is occupied.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q) && !out_o.ready)
    else $error("input stalled with a free stage");

  // Planar mode drops z.
  a_planar_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-2] && rdy[NST-1] && pt_q[NS+2].op == OP_PLANAR |=> out_o.out_z == '0)
    else $error("planar result with nonzero z");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the pipelined 3D point rotator with random handshake stalls.
`timescale 1ns / 1ps

module tb_top;
  import vrot_pkg::*;

  localparam int unsigned CW = VROT_COORD_WIDTH;
  localparam int unsigned AW = VROT_ANGLE_WIDTH;
  localparam int unsigned RANDOM_POINTS = 1150;
  localparam int unsigned TAIL_CYCLES = VROT_CORDIC_STAGES + 24;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_ONE = coord_t'(1 << 16);

  class rotation_scoreboard;
    point_t expected_q[$];
    int unsigned mismatches;
    longint atan_lut[24];

    function new();
      atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41722, 20861, 10430, 5215,
                   2608, 1304, 652, 326, 163, 81};
      mismatches = 0;
    endfunction

    // Cosine and sine in Q2.30 from a fixed-length CORDIC on a binary angle.
    function void trig_of_angle(input logic [AW-1:0] angle, output longint c, output longint s);
      logic [31:0] turn;
      logic [31:0] shifted;
      logic        flip;
      longint      zacc;
      longint      dx;
      longint      dy;
      turn = 32'(angle) << (32 - AW);
      shifted = turn + 32'h4000_0000;
      flip = shifted[31];
      if (flip) turn = turn + 32'h8000_0000;
      zacc = $signed(turn);
      c = longint'(GAIN_Q30);
      s = 0;
      for (int i = 0; i < VROT_CORDIC_STAGES && i < 24; i++) begin
        dx = s >>> i;
        dy = c >>> i;
        if (zacc >= 0) begin
          c = c - dx;
          s = s + dy;
          zacc = zacc - atan_lut[i];
        end else begin
          c = c + dx;
          s = s - dy;
          zacc = zacc + atan_lut[i];
        end
      end
      if (flip) begin
        c = -c;
        s = -s;
      end
    endfunction

    // Round to nearest (ties up) out of Q30, then clamp to the coordinate range.
    function coord_t mix_and_clamp(input longint a, input longint p, input longint b,
                                   input longint q);
      longint r;
      longint lo;
      longint hi;
      lo = -(64'sd1 <<< (CW - 1));
      hi = (64'sd1 <<< (CW - 1)) - 1;
      r = (a * p + b * q + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return coord_t'(r);
    endfunction

    function void note_point(input logic [1:0] op_bits, input logic [AW-1:0] angle,
                             input point_t p);
      longint c;
      longint s;
      point_t r;
      trig_of_angle(angle, c, s);
      case (vrot_op_e'(op_bits))
        OP_ROT_X: begin
          r.x = p.x;
          r.y = mix_and_clamp(p.y, c, p.z, -s);
          r.z = mix_and_clamp(p.y, s, p.z, c);
        end
        OP_ROT_Y: begin
          r.x = mix_and_clamp(p.x, c, p.z, s);
          r.y = p.y;
          r.z = mix_and_clamp(p.x, -s, p.z, c);
        end
        OP_ROT_Z: begin
          r.x = mix_and_clamp(p.x, c, p.y, -s);
          r.y = mix_and_clamp(p.x, s, p.y, c);
          r.z = p.z;
        end
        default: begin
          r.x = mix_and_clamp(p.x, c, p.y, -s);
          r.y = mix_and_clamp(p.x, s, p.y, c);
          r.z = '0;
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_point(input point_t got);
      point_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                   want.x, want.y, want.z, got.x, got.y, got.z);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_count;
  rotation_scoreboard board = new();

  vrot_in_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) in_if ();
  vrot_out_if #(.COORD_WIDTH(CW)) out_if ();

  vector_axis_rotator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Note every accepted point and check every accepted result.
  always @(posedge clk_i) begin
    point_t p;
    if (rst_ni && in_if.valid && in_if.ready) begin
      p.x = in_if.in_x;
      p.y = in_if.in_y;
      p.z = in_if.in_z;
      board.note_point(in_if.op, in_if.angle, p);
    end
  end

  always @(posedge clk_i) begin
    point_t p;
    if (rst_ni && out_if.valid && out_if.ready) begin
      p.x = out_if.out_x;
      p.y = out_if.out_y;
      p.z = out_if.out_z;
      board.check_point(p);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic coord_t rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return coord_t'($urandom);
      4, 5: return coord_t'($signed($urandom_range(0, 2 * 65536)) - 65536);
      6: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return coord_t'(1);
          default: return coord_t'(-1);
        endcase
      end
      default: return coord_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    logic [AW-1:0] quarter;
    quarter = AW'(1) << (AW - 2);
    if ($urandom_range(0, 99) >= 15) return AW'($urandom);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return quarter;
      2: return AW'(quarter * 2);
      3: return AW'(quarter * 3);
      4: return AW'(quarter - 1);
      5: return AW'(quarter * 3 - 1);
      6: return AW'(quarter + 1);
      default: return '1;
    endcase
  endfunction

  task automatic send_point(input vrot_op_e op, input logic [AW-1:0] angle, input coord_t x,
                            input coord_t y, input coord_t z, input int unsigned gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.angle <= angle;
    in_if.in_x  <= x;
    in_if.in_y  <= y;
    in_if.in_z  <= z;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Hold the input idle until every outstanding result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(100, 300)) @(posedge clk_i);
      end else begin
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin
    bit calm;
    vrot_op_e op;
    in_if.valid <= 1'b0;
    in_if.op    <= OP_ROT_X;
    in_if.angle <= '0;
    in_if.in_x  <= '0;
    in_if.in_y  <= '0;
    in_if.in_z  <= '0;
    cycle_count = 0;
    calm = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed: angle and coordinate extremes, quadrant edges, saturation, planar z.
    send_point(OP_ROT_X, 16'd0, C_MAX, C_ONE, -C_ONE, 0);
    send_point(OP_ROT_X, 16'd16384, 24'sd123, C_ONE, coord_t'(2 * C_ONE), 0);
    send_point(OP_ROT_X, 16'd32768, C_MIN, C_MAX, C_MIN, 0);
    send_point(OP_ROT_X, 16'd16385, '0, C_MAX, C_MIN, idle_len());
    send_point(OP_ROT_X, 16'd40960, C_MAX, C_MAX, C_MAX, 0);
    send_point(OP_ROT_Y, 16'd49152, C_ONE, -24'sd5, C_ONE, 0);
    send_point(OP_ROT_Y, 16'd8192, C_MAX, 24'sd7, C_MAX, idle_len());
    send_point(OP_ROT_Y, 16'd65535, -24'sd1, -24'sd1, -24'sd1, 0);
    send_point(OP_ROT_Y, 16'd32768, C_MIN, '0, C_MIN, 0);
    send_point(OP_ROT_Y, 16'd49151, C_MAX, C_MIN, C_ONE, 0);
    send_point(OP_ROT_Z, 16'd65535, C_MIN, C_MIN, C_MAX, 0);
    send_point(OP_ROT_Z, 16'd8192, C_MAX, C_MAX, '0, idle_len());
    send_point(OP_ROT_Z, 16'd24576, C_MIN, C_MIN, C_MIN, 0);
    send_point(OP_ROT_Z, 16'd49152, 24'sd1, -24'sd1, 24'sd5, 0);
    send_point(OP_ROT_Z, 16'd16383, C_ONE, C_MAX, C_MIN, 0);
    send_point(OP_PLANAR, 16'd0, C_ONE, C_ONE, C_MAX, 0);
    send_point(OP_PLANAR, 16'd16384, C_MAX, C_MIN, C_MIN, idle_len());
    send_point(OP_PLANAR, 16'd16383, C_MIN, C_MAX, C_ONE, 0);
    send_point(OP_PLANAR, 16'd32768, C_MIN, C_MAX, -C_ONE, 0);
    send_point(OP_PLANAR, 16'd57344, C_MAX, C_MIN, 24'sd1, 0);
    send_point(OP_PLANAR, 16'd65535, '0, '0, '0, 0);
    drain_results();

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n == 400 || n == 800) drain_results();
      if ($urandom_range(0, 49) == 0) calm = !calm;
      op = vrot_op_e'($urandom_range(0, 3));
      send_point(op, rand_angle(), rand_coord(), rand_coord(), rand_coord(),
                 calm ? 0 : idle_len());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
